// ----- hdl/mh64a_pkg.sv -----
// Package for the MurmurHash64A unit: mixing constants, controller states,
// datapath command and status structs. No dependencies.

package mh64a_pkg;

    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT = 47;

    localparam int WORD_W  = 64;
    localparam int CNT_W   = 4;
    localparam int LEN_W   = 32;
    localparam int SEED_W  = 32;
    localparam int HALF_W  = 32;
    localparam int BYTES   = 8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_LEN,
        S_LEN_WAIT,
        S_WORD,
        S_K1_WAIT,
        S_K2,
        S_K2_WAIT,
        S_HMUL,
        S_HMUL_WAIT,
        S_END,
        S_FIN_MUL,
        S_FIN_WAIT
    } t_state;

    // partial-product passes of the shared multiplier
    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LO,
        MP_X1,
        MP_X2
    } t_mul_ph;

    typedef enum logic [1:0] {
        SRC_LEN,
        SRC_WORD,
        SRC_K,
        SRC_HASH
    } t_mul_src;

    typedef enum logic [2:0] {
        HOP_NONE,
        HOP_INIT,
        HOP_TAIL,
        HOP_XOR_K,
        HOP_LOAD
    } t_hash_op;

    typedef enum logic [1:0] {
        KOP_NONE,
        KOP_XS_ACC,
        KOP_XS_HASH
    } t_k_op;

    typedef struct packed {
        logic     load_in;
        logic     mul_start;
        t_mul_src mul_src;
        t_hash_op hash_op;
        t_k_op    k_op;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic first;
        logic full;
        logic nonzero;
        logic last;
        logic mul_done;
        logic out_free;
    } t_dp_sts;

    // x ^ (x >> 47)
    function automatic logic [63:0] xor_shift(input logic [63:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

endpackage

// ----- hdl/mh64a_if.sv -----
// Request and result channel interfaces for the MurmurHash64A unit.
// Depends on nothing; widths match mh64a_pkg.

interface mh64a_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        first_word;
    logic        last_word;
    logic [31:0] message_length;

    modport source (output valid, data_word, valid_bytes, first_word, last_word,
                    message_length, input ready);
    modport sink   (input valid, data_word, valid_bytes, first_word, last_word,
                    message_length, output ready);
endinterface

interface mh64a_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

// ----- hdl/murmur_hash64a_unit.sv -----
// Top level of the MurmurHash64A unit: controller plus datapath.
// Depends on mh64a_pkg, mh64a_if, mh64a_ctrl, mh64a_dp.
//
//  channel   dir  handshake        contents
//  i_req     in   valid/ready      data_word, valid_bytes, first_word,
//                                  last_word, message_length
//  o_rsp     out  valid/ready      hash_value (one per last request)
//  i_cfg_*   in   write enable     hash_seed, 32 bits
//
// One request at a time. Each 64-bit product by the mixing constant costs
// three passes through the single 32x32 multiplier plus an issue state and
// a write-back; a full first last word needs five.
// Synchronous active-low reset clears seed, running hash, state and result valid.
// A held result does not stop the next request; only finalisation waits.

module murmur_hash64a_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [31:0]      i_cfg_wr_data,
    mh64a_req_if.sink        i_req,
    mh64a_rsp_if.source      o_rsp
);
    import mh64a_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_req.ready = w_in_ready;

    mh64a_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mh64a_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_data_word      (i_req.data_word),
        .i_valid_bytes    (i_req.valid_bytes),
        .i_first_word     (i_req.first_word),
        .i_last_word      (i_req.last_word),
        .i_message_length (i_req.message_length),
        .o_out_valid      (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_hash_value     (o_rsp.hash_value)
    );

endmodule

// ----- hdl/mh64a_mul.sv -----
// Iterative multiply by MIX_MUL, modulo 2^64, on one 32x32 multiplier.
// Three passes per product. Depends on mh64a_pkg.

module mh64a_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_operand,
    output logic        o_done,
    output logic [63:0] o_product
);
    import mh64a_pkg::*;

    t_mul_ph     r_ph,   n_ph;
    logic        r_done, n_done;
    logic [63:0] r_x,    n_x;
    logic [63:0] r_acc,  n_acc;

    logic [HALF_W-1:0] w_a, w_b;
    logic [63:0]       w_prod;

    always_comb begin
        unique case (r_ph)
            MP_X1: begin
                w_a = r_x[HALF_W-1:0];
                w_b = MIX_MUL[63:HALF_W];
            end
            MP_X2: begin
                w_a = r_x[63:HALF_W];
                w_b = MIX_MUL[HALF_W-1:0];
            end
            default: begin
                w_a = r_x[HALF_W-1:0];
                w_b = MIX_MUL[HALF_W-1:0];
            end
        endcase
    end

    assign w_prod = w_a * w_b;

    always_comb begin
        n_ph   = r_ph;
        n_done = r_done;
        n_x    = r_x;
        n_acc  = r_acc;
        if (i_start) begin
            n_x    = i_operand;
            n_ph   = MP_LO;
            n_done = 1'b0;
        end else begin
            unique case (r_ph)
                MP_LO: begin
                    n_acc = w_prod;
                    n_ph  = MP_X1;
                end
                MP_X1: begin
                    // cross terms only reach the upper half
                    n_acc = {r_acc[63:HALF_W] + w_prod[HALF_W-1:0], r_acc[HALF_W-1:0]};
                    n_ph  = MP_X2;
                end
                MP_X2: begin
                    n_acc  = {r_acc[63:HALF_W] + w_prod[HALF_W-1:0], r_acc[HALF_W-1:0]};
                    n_ph   = MP_IDLE;
                    n_done = 1'b1;
                end
                default: begin
                    n_ph = MP_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= MP_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
        end
        r_x   <= n_x;
        r_acc <= n_acc;
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ----- hdl/mh64a_dp.sv -----
// Datapath of the MurmurHash64A unit: request latch, seed, running hash,
// mixing register, multiplier and result register. Depends on mh64a_pkg, mh64a_mul.

module mh64a_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mh64a_pkg::t_dp_cmd    i_cmd,
    output mh64a_pkg::t_dp_sts    o_sts,
    input  logic                  i_cfg_wr_en,
    input  logic [31:0]           i_cfg_wr_data,
    input  logic [63:0]           i_data_word,
    input  logic [3:0]            i_valid_bytes,
    input  logic                  i_first_word,
    input  logic                  i_last_word,
    input  logic [31:0]           i_message_length,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [63:0]           o_hash_value
);
    import mh64a_pkg::*;

    logic [SEED_W-1:0] r_seed;
    logic [WORD_W-1:0] r_word;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_first;
    logic              r_last;
    logic [LEN_W-1:0]  r_len;
    logic [WORD_W-1:0] r_hash, n_hash;
    logic [WORD_W-1:0] r_k,    n_k;
    logic [WORD_W-1:0] r_out;
    logic              r_out_vld;

    logic [WORD_W-1:0] w_mul_opnd;
    logic [WORD_W-1:0] w_acc;
    logic              w_mul_done;
    logic [WORD_W-1:0] w_mask;
    logic [CNT_W-1:0]  w_cnt_sat;

    // byte counts above eight act as eight
    assign w_cnt_sat = i_valid_bytes[3] ? CNT_W'(BYTES) : i_valid_bytes;

    always_comb begin
        for (int i = 0; i < BYTES; i++) begin
            w_mask[i*8 +: 8] = (CNT_W'(i) < r_cnt) ? 8'hff : 8'h00;
        end
    end

    always_comb begin
        unique case (i_cmd.mul_src)
            SRC_LEN:  w_mul_opnd = {{(WORD_W-LEN_W){1'b0}}, r_len};
            SRC_WORD: w_mul_opnd = r_word;
            SRC_K:    w_mul_opnd = r_k;
            SRC_HASH: w_mul_opnd = r_hash;
            default:  w_mul_opnd = r_hash;
        endcase
    end

    mh64a_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.mul_start),
        .i_operand (w_mul_opnd),
        .o_done    (w_mul_done),
        .o_product (w_acc)
    );

    always_comb begin
        unique case (i_cmd.hash_op)
            HOP_INIT:  n_hash = {{(WORD_W-SEED_W){1'b0}}, r_seed} ^ w_acc;
            HOP_TAIL:  n_hash = r_hash ^ (r_word & w_mask);
            HOP_XOR_K: n_hash = r_hash ^ w_acc;
            HOP_LOAD:  n_hash = w_acc;
            default:   n_hash = r_hash;
        endcase
    end

    always_comb begin
        unique case (i_cmd.k_op)
            KOP_XS_ACC:  n_k = xor_shift(w_acc);
            KOP_XS_HASH: n_k = xor_shift(r_hash);
            default:     n_k = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= '0;
            r_hash    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
            r_hash <= n_hash;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (i_cmd.load_in) begin
            r_word  <= i_data_word;
            r_cnt   <= w_cnt_sat;
            r_first <= i_first_word;
            r_last  <= i_last_word;
            r_len   <= i_message_length;
        end
        r_k <= n_k;
        if (i_cmd.out_load) begin
            r_out <= xor_shift(w_acc);
        end
    end

    always_comb begin
        o_sts.first    = r_first;
        o_sts.full     = r_cnt[3];
        o_sts.nonzero  = (r_cnt != '0);
        o_sts.last     = r_last;
        o_sts.mul_done = w_mul_done;
        o_sts.out_free = !r_out_vld || i_out_ready;
    end

    assign o_out_valid  = r_out_vld;
    assign o_hash_value = r_out;

endmodule

// ----- hdl/mh64a_ctrl.sv -----
// Controller state machine of the MurmurHash64A unit: sequences the
// multiplier passes and hash updates per request. Depends on mh64a_pkg.

module mh64a_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mh64a_pkg::t_dp_sts  i_sts,
    output mh64a_pkg::t_dp_cmd  o_cmd
);
    import mh64a_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_START;
            S_START:     n_state = i_sts.first ? S_LEN : S_WORD;
            S_LEN:       n_state = S_LEN_WAIT;
            S_LEN_WAIT:  if (i_sts.mul_done) n_state = S_WORD;
            S_WORD: begin
                priority if (i_sts.full) n_state = S_K1_WAIT;
                else if (i_sts.nonzero)  n_state = S_HMUL;
                else                     n_state = S_END;
            end
            S_K1_WAIT:   if (i_sts.mul_done) n_state = S_K2;
            S_K2:        n_state = S_K2_WAIT;
            S_K2_WAIT:   if (i_sts.mul_done) n_state = S_HMUL;
            S_HMUL:      n_state = S_HMUL_WAIT;
            S_HMUL_WAIT: if (i_sts.mul_done) n_state = S_END;
            S_END:       n_state = i_sts.last ? S_FIN_MUL : S_IDLE;
            S_FIN_MUL:   n_state = S_FIN_WAIT;
            S_FIN_WAIT:  if (i_sts.mul_done && i_sts.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load_in   = 1'b0;
        o_cmd.mul_start = 1'b0;
        o_cmd.mul_src   = SRC_HASH;
        o_cmd.hash_op   = HOP_NONE;
        o_cmd.k_op      = KOP_NONE;
        o_cmd.out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_LEN: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_src   = SRC_LEN;
            end
            S_LEN_WAIT: begin
                if (i_sts.mul_done) o_cmd.hash_op = HOP_INIT;
            end
            S_WORD: begin
                priority if (i_sts.full) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_src   = SRC_WORD;
                end else if (i_sts.nonzero) begin
                    o_cmd.hash_op = HOP_TAIL;
                end
            end
            S_K1_WAIT: begin
                if (i_sts.mul_done) o_cmd.k_op = KOP_XS_ACC;
            end
            S_K2, S_FIN_MUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_src   = SRC_K;
            end
            S_K2_WAIT: begin
                if (i_sts.mul_done) o_cmd.hash_op = HOP_XOR_K;
            end
            S_HMUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_src   = SRC_HASH;
            end
            S_HMUL_WAIT: begin
                if (i_sts.mul_done) o_cmd.hash_op = HOP_LOAD;
            end
            S_END: begin
                // running hash stays unfinalised; finalise in the mixing register
                if (i_sts.last) o_cmd.k_op = KOP_XS_HASH;
            end
            S_FIN_WAIT: begin
                o_cmd.out_load = i_sts.mul_done && i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for murmur_hash64a_unit: a directed table, then random messages and stray requests.
// Depends on mh64a_pkg, mh64a_if and the unit itself.

module tb_top;

    import mh64a_pkg::*;

    localparam int NDIR        = 25;
    localparam int NPHASES     = 7;
    localparam int PHASE_ITEMS = 232;
    localparam int SETTLE      = 40;
    localparam int WDOG_LIMIT  = 3000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_STARVE,
        RX_PERIODIC
    } t_rx_mode;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        first;
        logic        last;
        logic [31:0] len;
        logic        fixed;
        logic [63:0] fixed_val;
    } t_vec;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    mh64a_req_if req_if ();
    mh64a_rsp_if rsp_if ();

    murmur_hash64a_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_req        (req_if),
        .o_rsp        (rsp_if)
    );

    // hash state mirrored by the bench
    logic [63:0] hash_acc;
    logic [31:0] cur_seed;
    logic [63:0] pending_digests[$];

    logic        fixed_en;
    logic [63:0] fixed_exp;
    int          err_count;
    int          idle_cycles;
    int          items_sent;
    int          burst_left;
    bit          gaps_on;
    t_rx_mode    rx_mode;
    logic [7:0]  rx_cyc;

    // rows with a typed value are trivially zero: seed 0, nothing mixed in
    t_vec dir_vecs [NDIR] = '{
        '{64'h0,                  4'd0,  1'b1, 1'b1, 32'd0,          1'b1, 64'h0},
        '{64'hffff_ffff_ffff_ffff, 4'd0,  1'b0, 1'b1, 32'hffff_ffff,  1'b1, 64'h0},
        '{64'hffff_ffff_ffff_ffff, 4'd8,  1'b1, 1'b1, 32'd8,          1'b0, 64'h0},
        '{64'h0,                  4'd8,  1'b1, 1'b1, 32'd8,          1'b0, 64'h0},
        '{64'hffff_ffff_ffff_ffff, 4'd1,  1'b1, 1'b1, 32'd1,          1'b0, 64'h0},
        '{64'h0123_4567_89ab_cdef, 4'd3,  1'b1, 1'b1, 32'd3,          1'b0, 64'h0},
        '{64'hffff_ffff_ffff_ffff, 4'd7,  1'b1, 1'b1, 32'd7,          1'b0, 64'h0},
        '{64'ha5a5_a5a5_a5a5_a5a5, 4'd9,  1'b1, 1'b1, 32'd8,          1'b0, 64'h0},
        '{64'h5a5a_5a5a_5a5a_5a5a, 4'd15, 1'b1, 1'b1, 32'd8,          1'b0, 64'h0},
        '{64'h8000_0000_0000_0001, 4'd8,  1'b1, 1'b0, 32'd20,         1'b0, 64'h0},
        '{64'hdead_beef_cafe_f00d, 4'd8,  1'b0, 1'b0, 32'd0,          1'b0, 64'h0},
        '{64'h1122_3344_5566_7788, 4'd4,  1'b0, 1'b1, 32'd0,          1'b0, 64'h0},
        '{64'hfedc_ba98_7654_3210, 4'd3,  1'b1, 1'b0, 32'd11,         1'b0, 64'h0},
        '{64'h0f0f_0f0f_0f0f_0f0f, 4'd8,  1'b0, 1'b1, 32'd0,          1'b0, 64'h0},
        '{64'hf0f0_f0f0_f0f0_f0f0, 4'd8,  1'b0, 1'b1, 32'd0,          1'b0, 64'h0},
        '{64'h0,                  4'd0,  1'b1, 1'b1, 32'hffff_ffff,  1'b0, 64'h0},
        '{64'h0000_0001_0000_0001, 4'd8,  1'b1, 1'b0, 32'd16,         1'b0, 64'h0},
        '{64'h7fff_ffff_ffff_fffe, 4'd8,  1'b0, 1'b0, 32'd0,          1'b0, 64'h0},
        '{64'hffff_ffff_ffff_ffff, 4'd0,  1'b0, 1'b1, 32'd0,          1'b0, 64'h0},
        '{64'h1234_5678_9abc_def0, 4'd0,  1'b1, 1'b0, 32'd5,          1'b0, 64'h0},
        '{64'hffff_ff00_0000_00ff, 4'd5,  1'b0, 1'b1, 32'd0,          1'b0, 64'h0},
        '{64'h0bad_f00d_0bad_f00d, 4'd8,  1'b1, 1'b0, 32'd24,         1'b0, 64'h0},
        '{64'haaaa_aaaa_aaaa_5555, 4'd2,  1'b1, 1'b1, 32'd2,          1'b0, 64'h0},
        '{64'h0102_0304_0506_0708, 4'd8,  1'b1, 1'b1, 32'd1000,       1'b0, 64'h0},
        '{64'h5555_5555_5555_5555, 4'd0,  1'b0, 1'b0, 32'd0,          1'b0, 64'h0}
    };

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // one request through the hash; returns the finalised digest on a last word
    task automatic step_hash(input logic [63:0] word, input logic [3:0] nbytes,
                             input logic first, input logic last, input logic [31:0] len,
                             output bit emit, output logic [63:0] digest);
        logic [63:0] h;
        logic [63:0] k;
        logic [63:0] mask;
        int          n;
        n = (nbytes > 4'd8) ? 8 : int'(nbytes);
        h = hash_acc;
        if (first)
            h = {32'd0, cur_seed} ^ ({32'd0, len} * MIX_MUL);
        if (n == 8) begin
            k = word * MIX_MUL;
            k = k ^ (k >> MIX_SHIFT);
            k = k * MIX_MUL;
            h = (h ^ k) * MIX_MUL;
        end else if (n != 0) begin
            mask = (64'd1 << (n * 8)) - 64'd1;
            h = (h ^ (word & mask)) * MIX_MUL;
        end
        hash_acc = h;
        emit     = last;
        digest   = h ^ (h >> MIX_SHIFT);
        digest   = digest * MIX_MUL;
        digest   = digest ^ (digest >> MIX_SHIFT);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    // called and returns at a falling edge
    task automatic send_req(input logic [63:0] word, input logic [3:0] nbytes,
                            input logic first, input logic last, input logic [31:0] len,
                            input logic fixed, input logic [63:0] fixed_val);
        int gap;
        if (burst_left == 0) begin
            if (gaps_on) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30)
                                                  : $urandom_range(1, 4);
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req_if.valid          <= 1'b1;
        req_if.data_word      <= word;
        req_if.valid_bytes    <= nbytes;
        req_if.first_word     <= first;
        req_if.last_word      <= last;
        req_if.message_length <= len;
        fixed_en              <= fixed;
        fixed_exp             <= fixed_val;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        if (!(nbytes == 4'd0 && !first && !last))
            items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [3:0] full_count();
        return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
    endfunction

    // well-formed message, occasionally with a bogus length field
    task automatic send_message();
        int          total;
        int          nfull;
        int          tail;
        bit          closer;
        logic [31:0] len_field;
        case ($urandom_range(0, 9))
            0: begin
                total = 0;
            end
            1: begin
                total = $urandom_range(64, 200);
            end
            default: begin
                total = $urandom_range(1, 40);
            end
        endcase
        nfull     = total / 8;
        tail      = total % 8;
        len_field = ($urandom_range(0, 9) == 0) ? $urandom : 32'(total);
        if (total == 0) begin
            send_req(rnd64(), 4'd0, 1'b1, 1'b1, len_field, 1'b0, 64'h0);
            return;
        end
        closer = (tail == 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < nfull; i++) begin
            send_req(rnd64(), full_count(), i == 0,
                     (tail == 0) && !closer && (i == nfull - 1),
                     (i == 0) ? len_field : $urandom, 1'b0, 64'h0);
        end
        if (tail != 0)
            send_req(rnd64(), 4'(tail), nfull == 0, 1'b1,
                     (nfull == 0) ? len_field : $urandom, 1'b0, 64'h0);
        if (closer)
            send_req(rnd64(), 4'd0, 1'b0, 1'b1, $urandom, 1'b0, 64'h0);
    endtask

    task automatic drain_and_settle();
        while (pending_digests.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] val);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // result side back-pressure
    always @(negedge i_clk) begin
        rx_cyc <= rx_cyc + 8'd1;
        if (rx_cyc[5:0] == 6'd0)
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN: begin
                rsp_if.ready <= 1'b1;
            end
            RX_COIN: begin
                rsp_if.ready <= 1'($urandom_range(0, 1));
            end
            RX_STARVE: begin
                rsp_if.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                rsp_if.ready <= rx_cyc[2];
            end
        endcase
    end

    always @(posedge i_clk) begin : scoreboard
        bit          emit;
        bit          moved;
        logic [63:0] digest;
        logic [63:0] want;
        moved = 1'b0;
        if (!i_rst_n) begin
            hash_acc = 64'h0;
            cur_seed = 32'h0;
        end else begin
            if (i_cfg_wr_en)
                cur_seed = i_cfg_wr_data;
            if (req_if.valid && req_if.ready) begin
                moved = 1'b1;
                step_hash(req_if.data_word, req_if.valid_bytes, req_if.first_word,
                          req_if.last_word, req_if.message_length, emit, digest);
                if (emit)
                    pending_digests.push_back(fixed_en ? fixed_exp : digest);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                moved = 1'b1;
                if (pending_digests.size() == 0) begin
                    report_mismatch("hash_value with no request pending",
                                    rsp_if.hash_value, 64'h0);
                end else begin
                    want = pending_digests.pop_front();
                    if (rsp_if.hash_value !== want)
                        report_mismatch("hash_value", rsp_if.hash_value, want);
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WDOG_LIMIT)
            @(posedge i_clk);
        $display("Timeout: no handshake for %0d cycles", WDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [31:0] seeds [NPHASES];
        i_rst_n               = 1'b0;
        i_cfg_wr_en           = 1'b0;
        i_cfg_wr_data         = 32'h0;
        req_if.valid          = 1'b0;
        req_if.data_word      = 64'h0;
        req_if.valid_bytes    = 4'd0;
        req_if.first_word     = 1'b0;
        req_if.last_word      = 1'b0;
        req_if.message_length = 32'h0;
        rsp_if.ready          = 1'b0;
        fixed_en              = 1'b0;
        fixed_exp             = 64'h0;
        err_count             = 0;
        idle_cycles           = 0;
        items_sent            = 0;
        burst_left            = 0;
        gaps_on               = 1'b1;
        rx_mode               = RX_OPEN;
        rx_cyc                = 8'd0;
        seeds = '{32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h1, $urandom, $urandom, $urandom};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed requests run with the seed left by reset
        foreach (dir_vecs[i])
            send_req(dir_vecs[i].word, dir_vecs[i].nbytes, dir_vecs[i].first,
                     dir_vecs[i].last, dir_vecs[i].len, dir_vecs[i].fixed,
                     dir_vecs[i].fixed_val);
        req_if.valid <= 1'b0;

        for (int p = 0; p < NPHASES; p++) begin
            drain_and_settle();
            write_seed(seeds[p]);
            gaps_on    = (p % 3) != 2;
            burst_left = 0;
            while (items_sent < NDIR + (p + 1) * PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_message();
                end else begin
                    repeat ($urandom_range(1, 3))
                        send_req(rnd64(), 4'($urandom_range(0, 15)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 $urandom, 1'b0, 64'h0);
                end
            end
            req_if.valid <= 1'b0;
        end

        drain_and_settle();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
